// ===== hw/rtl/tkpo_pkg.sv =====
// Package: shared constants, types and the place-weight table for the stage order unit.
`timescale 1ns / 1ps

package tkpo_pkg;

  // Number of stages in the order and number of orders (8!)
  localparam int unsigned SLOT_COUNT  = 8;
  localparam int unsigned ORDER_COUNT = 40320;

  // Reset value of the base time register
  localparam logic [31:0] BASE_TIME_RESET = 32'd1538556426;

  // 40320 = 315 * 2^7: the low 7 bits pass through, the rest is reduced mod 315
  localparam int unsigned LOW_BITS = 7;
  localparam logic [24:0] ODD_MOD  = 25'd315;

  // floor(2^33 / 315): quotient estimate is low by at most one
  localparam logic [49:0] RECIP_M     = 50'd27269633;
  localparam int unsigned RECIP_SHIFT = 33;

  typedef logic [2:0] slot_t;
  typedef slot_t [SLOT_COUNT-1:0] slot_arr_t;

  // Data handed from cell to cell: remaining rank and the partially built order
  typedef struct packed {
    logic [15:0] rem;
    slot_arr_t   ord;
  } cell_data_t;

  // (7-pos)!: weight of the factorial-base digit at position pos
  function automatic logic [15:0] place_weight(input int unsigned pos);
    logic [15:0] w;
    w = 16'd1;
    for (int unsigned k = 1; k < SLOT_COUNT; k++) begin
      if (k < SLOT_COUNT - pos) begin
        w = 16'(w * k);
      end
    end
    return w;
  endfunction

endpackage

// ===== hw/rtl/tkpo_if.sv =====
// Interfaces: input time channel, result order channel and base time write channel.
`timescale 1ns / 1ps

interface tkpo_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_time;
  modport source (output valid, output block_time, input ready);
  modport sink   (input valid, input block_time, output ready);
endinterface

interface tkpo_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] slot0;
  logic [2:0] slot1;
  logic [2:0] slot2;
  logic [2:0] slot3;
  logic [2:0] slot4;
  logic [2:0] slot5;
  logic [2:0] slot6;
  logic [2:0] slot7;
  modport source (output valid, output slot0, output slot1, output slot2, output slot3,
                  output slot4, output slot5, output slot6, output slot7, input ready);
  modport sink   (input valid, input slot0, input slot1, input slot2, input slot3,
                  input slot4, input slot5, input slot6, input slot7, output ready);
endinterface

interface tkpo_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] base_time;
  modport source (output valid, output base_time, input ready);
  modport sink   (input valid, input base_time, output ready);
endinterface

// ===== hw/rtl/tkpo_reduce.sv =====
// Rank pipeline: (block_time - base_time) mod 40320 in four registered stages.
`timescale 1ns / 1ps

module tkpo_reduce
  import tkpo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] block_time,
  input  logic [31:0] base_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] rank
);

  logic [3:0]  vld;
  logic [3:0]  adv;

  logic [31:0] diff;
  logic [24:0] q_s1;
  logic [6:0]  lo_s1;
  logic [16:0] quot_s1;
  logic [9:0]  r_s2;
  logic [6:0]  lo_s2;
  logic [15:0] rank_s3;

  logic [49:0] prod;
  logic [24:0] qm;
  logic [24:0] r_full;
  logic [9:0]  r_fix;

  // stage enables: a stage loads when it is empty or its contents move on
  always_comb begin
    adv[3] = !vld[3] || out_ready;
    for (int k = 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
    end
  end

  // quotient estimate by reciprocal, then remainder with one correction
  assign prod   = 50'(diff[31:LOW_BITS]) * RECIP_M;
  assign qm     = {8'b0, quot_s1} * ODD_MOD;
  assign r_full = q_s1 - qm;
  assign r_fix  = (r_s2 >= 10'(ODD_MOD)) ? 10'(r_s2 - 10'(ODD_MOD)) : r_s2;

  // payload registers
  always_ff @(posedge clk) begin
    if (adv[0] && in_valid) begin
      diff <= block_time - base_time;
    end
    if (adv[1] && vld[0]) begin
      q_s1    <= diff[31:LOW_BITS];
      lo_s1   <= diff[LOW_BITS-1:0];
      quot_s1 <= prod[49:RECIP_SHIFT];
    end
    if (adv[2] && vld[1]) begin
      r_s2  <= r_full[9:0];
      lo_s2 <= lo_s1;
    end
    if (adv[3] && vld[2]) begin
      rank_s3 <= {r_fix[8:0], lo_s2};
    end
  end

  assign out_valid = vld[3];
  assign rank      = rank_s3;

endmodule

// ===== hw/rtl/tkpo_cell.sv =====
// Unrank cell: takes one factorial-base digit and moves the chosen stage into its position.
`timescale 1ns / 1ps

module tkpo_cell
  import tkpo_pkg::*;
#(
  parameter int unsigned POS = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cell_data_t in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cell_data_t out_data
);

  localparam logic [15:0] WEIGHT = place_weight(POS);

  logic [2:0]  digit;
  logic [2:0]  sel;
  cell_data_t  data_next;

  // digit = rem / WEIGHT, found by comparing against the multiples
  always_comb begin
    digit = '0;
    for (int unsigned k = 1; k < SLOT_COUNT; k++) begin
      if ({1'b0, in_data.rem} >= 17'(k * WEIGHT)) begin
        digit = 3'(k);
      end
    end
  end

  assign sel = 3'(POS) + digit;

  // rotate the chosen stage to this position, shift the skipped ones up by one
  always_comb begin
    data_next.rem = 16'(in_data.rem - 16'(digit * WEIGHT));
    for (int unsigned j = 0; j < SLOT_COUNT; j++) begin
      if (j == POS) begin
        data_next.ord[j] = in_data.ord[sel];
      end else if (j > POS && j <= POS + digit) begin
        data_next.ord[j] = in_data.ord[j-1];
      end else begin
        data_next.ord[j] = in_data.ord[j];
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

// ===== hw/rtl/time_keyed_permutation_order_unit.sv =====
// Top level: time-keyed stage order, rank pipeline followed by a chain of unrank cells.
//
//  channel  modport     payload             role
//  stamp    sink        block_time[31:0]    block time in
//  order    source      slot0..slot7[2:0]   stage order out
//  cfg      sink        base_time[31:0]     base time write
//
// One item per cycle sustained while order is ready; 4 rank stages, then 7 unrank cells.
// Each stage holds one item, so a stalled output backs up stage by stage.
// Synchronous active-high reset empties the pipeline and loads the default base time.
// cfg is always ready; the user must change base time only while the pipeline is empty (not enforced).
`timescale 1ns / 1ps

module time_keyed_permutation_order_unit
  import tkpo_pkg::*;
(
  input logic        clk,
  input logic        rst,
  tkpo_in_if.sink    stamp,
  tkpo_out_if.source order,
  tkpo_cfg_if.sink   cfg
);

  localparam int unsigned CELLS = SLOT_COUNT - 1;
  localparam int unsigned DEPTH = 4 + CELLS;

  logic [31:0]    base_time;
  logic           rank_valid;
  logic [15:0]    rank;
  logic [CELLS:0] cv;
  logic [CELLS:0] cr;
  cell_data_t     cd [CELLS+1];

  // base time register
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_time <= BASE_TIME_RESET;
    end else if (cfg.valid && cfg.ready) begin
      base_time <= cfg.base_time;
    end
  end

  // rank = (block_time - base_time) mod 8!
  tkpo_reduce u_reduce (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (stamp.valid),
    .in_ready   (stamp.ready),
    .block_time (stamp.block_time),
    .base_time  (base_time),
    .out_valid  (rank_valid),
    .out_ready  (cr[0]),
    .rank       (rank)
  );

  // chain head: rank with the identity order
  assign cv[0] = rank_valid;
  always_comb begin
    cd[0].rem = rank;
    for (int unsigned j = 0; j < SLOT_COUNT; j++) begin
      cd[0].ord[j] = slot_t'(j);
    end
  end

  // one cell per position; the last position needs no cell
  for (genvar p = 0; p < CELLS; p++) begin : g_cell
    tkpo_cell #(.POS(p)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[p]),
      .in_ready  (cr[p]),
      .in_data   (cd[p]),
      .out_valid (cv[p+1]),
      .out_ready (cr[p+1]),
      .out_data  (cd[p+1])
    );
  end

  // result channel
  assign order.valid = cv[CELLS];
  assign cr[CELLS]   = order.ready;
  assign order.slot0 = cd[CELLS].ord[0];
  assign order.slot1 = cd[CELLS].ord[1];
  assign order.slot2 = cd[CELLS].ord[2];
  assign order.slot3 = cd[CELLS].ord[3];
  assign order.slot4 = cd[CELLS].ord[4];
  assign order.slot5 = cd[CELLS].ord[5];
  assign order.slot6 = cd[CELLS].ord[6];
  assign order.slot7 = cd[CELLS].ord[7];

  // items in flight and stage coverage of the result, for checking
  logic [3:0] inflight;
  logic [7:0] seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= 4'(inflight + 4'(stamp.valid && stamp.ready)
                  - 4'(order.valid && order.ready));
    end
  end

  always_comb begin
    seen = '0;
    for (int unsigned j = 0; j < SLOT_COUNT; j++) begin
      seen[cd[CELLS].ord[j]] = 1'b1;
    end
  end

`ifndef SYNTH
  // every result names each stage exactly once
  a_perm: assert property (@(posedge clk) disable iff (rst)
    order.valid |-> (seen == 8'hFF))
    else $error("result is not a permutation of the stages");

  // rank entering the chain is below 8!
  a_rank: assert property (@(posedge clk) disable iff (rst)
    rank_valid |-> (rank < 16'(ORDER_COUNT)))
    else $error("rank out of range");

  // no more items in flight than stages
  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 4'(DEPTH))
    else $error("more items in flight than pipeline stages");

  // no result without an item in flight
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (inflight == 4'd0) |-> !order.valid)
    else $error("result shown with empty pipeline");
`endif

endmodule

// ===== tb/time_keyed_permutation_order_unit_tb.sv =====
// Testbench: checks the time-keyed stage order unit against a behavioral unranker, under random stalls.
`timescale 1ns / 1ps

module time_keyed_permutation_order_unit_tb;
  import tkpo_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef struct {
    logic [31:0] stamp;
    slot_arr_t   slots;
  } order_exp_t;

  logic clk;
  logic rst;

  tkpo_in_if  stamp_if();
  tkpo_out_if order_if();
  tkpo_cfg_if cfg_if();

  time_keyed_permutation_order_unit u_top (
    .clk   (clk),
    .rst   (rst),
    .stamp (stamp_if),
    .order (order_if),
    .cfg   (cfg_if)
  );

  logic [31:0] stamp_queue[$];
  order_exp_t  order_due[$];
  logic [31:0] base_copy;
  logic        stamp_took;
  int          idle_pct;
  int          stamps_queued;
  int          stamps_taken;
  int          orders_checked;
  int          base_writes;
  int          fault_count;
  int          stall_cycles;

  // Order of stages for one block time: rank the wrapped difference, then unrank
  function automatic slot_arr_t stage_order(logic [31:0] stamp, logic [31:0] base);
    int unsigned weight[8] = '{5040, 720, 120, 24, 6, 2, 1, 1};
    slot_t       avail[8];
    slot_arr_t   ord;
    logic [31:0] rank;
    int unsigned digit;
    int unsigned left;
    rank = (stamp - base) % 32'd40320;
    left = 8;
    for (int k = 0; k < 8; k++) avail[k] = slot_t'(k);
    for (int pos = 0; pos < 8; pos++) begin
      digit = rank / weight[pos];
      rank  = rank % weight[pos];
      if (digit >= left) digit = left - 1;
      ord[pos] = avail[digit];
      for (int unsigned k = digit; k + 1 < left; k++) avail[k] = avail[k + 1];
      left--;
    end
    return ord;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Input driver and output ready, both changed on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      stamp_if.valid      <= 1'b0;
      stamp_if.block_time <= '0;
      order_if.ready      <= 1'b0;
    end else begin
      if (!stamp_if.valid || stamp_took) begin
        if (stamp_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
          stamp_if.valid      <= 1'b1;
          stamp_if.block_time <= stamp_queue.pop_front();
        end else begin
          stamp_if.valid <= 1'b0;
        end
      end
      order_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // Monitor: track base writes, predict on input transfer, check on output transfer
  always @(posedge clk) begin
    slot_arr_t  got;
    order_exp_t want;
    if (rst) begin
      stamp_took <= 1'b0;
      base_copy = BASE_TIME_RESET;
    end else begin
      stamp_took <= stamp_if.valid && stamp_if.ready;
      if (cfg_if.valid && cfg_if.ready) begin
        base_copy = cfg_if.base_time;
        base_writes++;
      end
      if (stamp_if.valid && stamp_if.ready) begin
        want.stamp = stamp_if.block_time;
        want.slots = stage_order(stamp_if.block_time, base_copy);
        order_due.push_back(want);
        stamps_taken++;
      end
      if (order_if.valid && order_if.ready) begin
        got[0] = order_if.slot0;
        got[1] = order_if.slot1;
        got[2] = order_if.slot2;
        got[3] = order_if.slot3;
        got[4] = order_if.slot4;
        got[5] = order_if.slot5;
        got[6] = order_if.slot6;
        got[7] = order_if.slot7;
        if (order_due.size() == 0) begin
          $display("%0t: unexpected order, expected none, actual %h", $time, got);
          fault_count++;
        end else begin
          want = order_due.pop_front();
          for (int j = 0; j < 8; j++) begin
            if (got[j] !== want.slots[j]) begin
              $display("%0t: block_time %h slot%0d expected %0d actual %0d",
                       $time, want.stamp, j, want.slots[j], got[j]);
              fault_count++;
            end
          end
          orders_checked++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst || (stamp_if.valid && stamp_if.ready) || (order_if.valid && order_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
      $display("time_keyed_permutation_order_unit_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_stamp(input logic [31:0] stamp);
    stamp_queue.push_back(stamp);
    stamps_queued++;
  endtask

  // Random block times: mostly full range, some aimed at rank boundaries and the wrap
  task automatic push_random(input int count, input logic [31:0] base);
    logic [31:0] stamp;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        6, 7:    stamp = base + $urandom_range(40319);
        8:       stamp = base + $urandom_range(106000) * 40320 + $urandom_range(3);
        9:       stamp = base - $urandom_range(50000);
        default: stamp = $urandom;
      endcase
      push_stamp(stamp);
    end
  endtask

  task automatic write_base(input logic [31:0] value);
    @(negedge clk);
    cfg_if.valid     <= 1'b1;
    cfg_if.base_time <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until every queued time is taken and every order has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (stamps_taken != stamps_queued || order_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(input logic [31:0] base, input int count, input int pct);
    write_base(base);
    idle_pct = pct;
    push_random(count, base);
    wait_drained();
  endtask

  // Stimulus sequence
  initial begin
    logic [31:0] base;
    stamp_if.valid      = 1'b0;
    stamp_if.block_time = '0;
    order_if.ready      = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.base_time    = '0;
    stamp_took          = 1'b0;
    base_copy           = BASE_TIME_RESET;
    idle_pct            = 10;
    stamps_queued       = 0;
    stamps_taken        = 0;
    orders_checked      = 0;
    base_writes         = 0;
    fault_count         = 0;
    stall_cycles        = 0;
    rst                 = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: identity, reversed order, rank boundaries, wrap below base, field extremes
    base = BASE_TIME_RESET;
    push_stamp(base);
    push_stamp(base + 1);
    push_stamp(base + 2);
    push_stamp(base + 719);
    push_stamp(base + 720);
    push_stamp(base + 5039);
    push_stamp(base + 5040);
    push_stamp(base + 40319);
    push_stamp(base + 40320);
    push_stamp(base + 40321);
    push_stamp(base - 1);
    push_stamp(32'h0000_0000);
    push_stamp(32'hFFFF_FFFF);
    push_stamp(32'h8000_0000);
    push_stamp(32'h7FFF_FFFF);
    push_stamp(32'hAAAA_AAAA);
    push_stamp(32'h5555_5555);
    wait_drained();

    // Base time extremes and random settings; one phase runs with no idling
    run_phase(32'h0000_0000, 150, 10);
    push_stamp(32'hFFFF_FFFF);
    push_stamp(32'd40319);
    wait_drained();
    run_phase(32'hFFFF_FFFF, 150, 10);
    run_phase($urandom, 200, 0);
    run_phase(32'h8000_0000, 150, 10);
    run_phase($urandom, 100, 10);
    run_phase(BASE_TIME_RESET, 130, 10);

    $display("covered %0d block times over %0d base time settings, %0d orders checked",
             stamps_taken, base_writes + 1, orders_checked);
    if (fault_count == 0) begin
      $display("time_keyed_permutation_order_unit_tb: done, clean");
    end else begin
      $display("time_keyed_permutation_order_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tkpo_pkg.sv
hw/rtl/tkpo_if.sv
hw/rtl/tkpo_reduce.sv
hw/rtl/tkpo_cell.sv
hw/rtl/time_keyed_permutation_order_unit.sv
tb/time_keyed_permutation_order_unit_tb.sv
